### rtl/sprite_stripe_clip_split_assert.svh
// Assertion macros for the sprite stripe splitter checker.
// Needs nothing else; included by the checker file.
`ifndef SPRITE_STRIPE_CLIP_SPLIT_ASSERT_SVH
`define SPRITE_STRIPE_CLIP_SPLIT_ASSERT_SVH

// same-cycle implication, disabled while dis is high
`define SSC_ASSERT_IMPLY(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("ssc assertion failed");

// next-cycle implication, disabled while dis is high
`define SSC_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("ssc assertion failed");

`endif

### rtl/ssc_pkg.sv
// Shared constants and types of the sprite stripe splitter.
// No dependencies; used by every module of the block.
`default_nettype none
package ssc_pkg;

    localparam int SCREEN_W    = 320;
    localparam int SCREEN_H    = 240;
    localparam int BAND_SHIFT  = 4;
    localparam int BAND_HEIGHT = 1 << BAND_SHIFT;
    localparam int BAND_COUNT  = 15;
    localparam int SPR         = 32;
    localparam int SPR_SHIFT   = 5;
    localparam int CX_W        = $clog2(SCREEN_W);
    localparam int ROWS_W      = BAND_SHIFT + 1;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // command slots of one sprite
    localparam int CMD_START = 0;
    localparam int CMD_MID   = 1;
    localparam int CMD_END   = 2;
    localparam int CMD_N     = 3;

    typedef struct packed {
        logic [CMD_N-1:0]  mask;
        logic [5:0]        band_s;
        logic [5:0]        band_m;
        logic [5:0]        band_e;
        logic [9:0]        src_s;
        logic [9:0]        src_m;
        logic [9:0]        src_e;
        logic [14:0]       dst_s;
        logic [CX_W-1:0]   cx;
        logic [5:0]        ppr;
        logic [ROWS_W-1:0] rows_s;
        logic [ROWS_W-1:0] rows_e;
        logic [31:0]       bmp;
        logic [31:0]       pal;
    } t_job;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_qstat;

endpackage
`default_nettype wire

### rtl/ssc_front.sv
// Front end: culls, clips and splits one sprite into a job of up to three commands.
// Depends on ssc_pkg.
`default_nettype none
module ssc_front (
    input  wire logic signed [11:0] i_pos_x,
    input  wire logic signed [11:0] i_pos_y,
    input  wire logic [31:0]        i_sprite_base,
    input  wire logic [31:0]        i_palette_base,
    output ssc_pkg::t_job           o_job,
    output logic                    o_keep
);

    localparam int BW = 13 - ssc_pkg::BAND_SHIFT;
    localparam logic signed [12:0] XY_LO  = 13'(-ssc_pkg::SPR);
    localparam logic signed [12:0] X_HI   = 13'(ssc_pkg::SCREEN_W);
    localparam logic signed [12:0] Y_HI   = 13'(ssc_pkg::SCREEN_H);
    localparam logic signed [12:0] X_CLIP = 13'(ssc_pkg::SCREEN_W - ssc_pkg::SPR);
    localparam logic signed [12:0] SPAN   = 13'(ssc_pkg::SPR - 1);
    localparam logic signed [BW-1:0] BAND_LIM = BW'(ssc_pkg::BAND_COUNT);

    function automatic logic band_ok(input logic signed [BW-1:0] b);
        band_ok = !b[BW-1] && (b < BAND_LIM);
    endfunction

    logic signed [12:0]          x13, y13, ye, xn, xr;
    logic signed [BW-1:0]        b_s, b_m, b_e;
    logic                        in_view, has_mid, has_end;
    logic [ssc_pkg::BAND_SHIFT-1:0] yrow;
    logic [ssc_pkg::SPR_SHIFT-1:0]  src0;
    logic [ssc_pkg::ROWS_W-1:0]  rows_s;
    logic [9:0]                  src_m;
    logic [ssc_pkg::CMD_N-1:0]   mask;

    always_comb begin
        x13 = {i_pos_x[11], i_pos_x};
        y13 = {i_pos_y[11], i_pos_y};
        ye  = y13 + SPAN;
        xn  = -x13;
        xr  = X_HI - x13;

        in_view = (x13 > XY_LO) && (x13 < X_HI) && (y13 > XY_LO) && (y13 < Y_HI);

        // floor division by the band height
        b_s = y13[12:ssc_pkg::BAND_SHIFT];
        b_e = ye[12:ssc_pkg::BAND_SHIFT];
        b_m = b_s + BW'(1);
        has_mid = b_e > b_m;
        has_end = b_e > b_s;

        yrow   = y13[ssc_pkg::BAND_SHIFT-1:0];
        rows_s = ssc_pkg::ROWS_W'(ssc_pkg::BAND_HEIGHT) - {1'b0, yrow};
        src0   = x13[12] ? xn[ssc_pkg::SPR_SHIFT-1:0] : '0;
        src_m  = 10'(src0) + 10'({rows_s, {ssc_pkg::SPR_SHIFT{1'b0}}});

        mask = '0;
        mask[ssc_pkg::CMD_START] = band_ok(b_s);
        mask[ssc_pkg::CMD_MID]   = has_mid && band_ok(b_m);
        mask[ssc_pkg::CMD_END]   = has_end && band_ok(b_e);
        o_keep = in_view && (|mask);

        o_job.mask   = mask;
        o_job.band_s = b_s[5:0];
        o_job.band_m = b_m[5:0];
        o_job.band_e = b_e[5:0];
        o_job.src_s  = 10'(src0);
        o_job.src_m  = src_m;
        o_job.src_e  = src_m + (has_mid ? 10'(ssc_pkg::BAND_HEIGHT * ssc_pkg::SPR) : 10'd0);
        o_job.cx     = x13[12] ? '0 : x13[ssc_pkg::CX_W-1:0];
        o_job.dst_s  = 15'(yrow) * 15'(ssc_pkg::SCREEN_W) + 15'(o_job.cx);
        if (x13[12]) begin
            o_job.ppr = 6'(ssc_pkg::SPR) - 6'(src0);
        end else if (x13 > X_CLIP) begin
            o_job.ppr = xr[5:0];
        end else begin
            o_job.ppr = 6'(ssc_pkg::SPR);
        end
        o_job.rows_s = rows_s;
        // rows in the end band: (y + 31) mod band height, plus one
        o_job.rows_e = {1'b0, ye[ssc_pkg::BAND_SHIFT-1:0]} + ssc_pkg::ROWS_W'(1);
        o_job.bmp    = i_sprite_base;
        o_job.pal    = i_palette_base;
    end

endmodule
`default_nettype wire

### rtl/ssc_queue.sv
// Two-entry job queue between the front end and the command issuer.
// Depends on ssc_pkg.
`default_nettype none
module ssc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  ssc_pkg::t_job      i_job,
    input  wire logic          i_pop,
    output ssc_pkg::t_job      o_head,
    output ssc_pkg::t_qstat    o_stat
);

    ssc_pkg::t_job                 r_mem [ssc_pkg::QDEPTH];
    logic [ssc_pkg::QPTR_W-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [ssc_pkg::QCNT_W-1:0]    r_cnt, n_cnt;

    always_comb begin
        n_wp  = i_push ? r_wp + ssc_pkg::QPTR_W'(1) : r_wp;
        n_rp  = i_pop  ? r_rp + ssc_pkg::QPTR_W'(1) : r_rp;
        n_cnt = r_cnt + ssc_pkg::QCNT_W'(i_push) - ssc_pkg::QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_head           = r_mem[r_rp];
    assign o_stat.not_empty = (r_cnt != '0);
    assign o_stat.full      = (r_cnt == ssc_pkg::QCNT_W'(ssc_pkg::QDEPTH));

endmodule
`default_nettype wire

### rtl/ssc_back.sv
// Command issuer: walks the head job's command mask, one blit command per cycle.
// Depends on ssc_pkg.
`default_nettype none
module ssc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  ssc_pkg::t_job      i_head,
    input  ssc_pkg::t_qstat    i_stat,
    input  wire logic [7:0]    i_skip,
    output logic               o_pop,
    output logic               o_valid,
    output logic [5:0]         o_stripe_index,
    output logic [9:0]         o_src_start_px,
    output logic [14:0]        o_dst_start_px,
    output logic [5:0]         o_pixels_per_row,
    output logic [5:0]         o_row_count,
    output logic [31:0]        o_bitmap_handle,
    output logic [31:0]        o_colour_table_handle,
    output logic [7:0]         o_skip_index,
    output logic               o_last_command
);

    logic [ssc_pkg::CMD_N-1:0] r_done, n_done, rem, sel;
    logic                      r_valid, last;
    logic [5:0]                band, rows;
    logic [9:0]                src;
    logic [14:0]               dst;

    always_comb begin
        rem  = i_stat.not_empty ? (i_head.mask & ~r_done) : '0;
        sel  = '0;
        band = i_head.band_e;
        src  = i_head.src_e;
        dst  = 15'(i_head.cx);
        rows = 6'(i_head.rows_e);
        priority if (rem[ssc_pkg::CMD_START]) begin
            sel[ssc_pkg::CMD_START] = 1'b1;
            band = i_head.band_s;
            src  = i_head.src_s;
            dst  = i_head.dst_s;
            rows = 6'(i_head.rows_s);
        end else if (rem[ssc_pkg::CMD_MID]) begin
            sel[ssc_pkg::CMD_MID] = 1'b1;
            band = i_head.band_m;
            src  = i_head.src_m;
            rows = 6'(ssc_pkg::BAND_HEIGHT);
        end else if (rem[ssc_pkg::CMD_END]) begin
            sel[ssc_pkg::CMD_END] = 1'b1;
        end
        last   = (rem & ~sel) == '0;
        o_pop  = (|rem) && last;
        n_done = o_pop ? '0 : (r_done | sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_done  <= n_done;
            r_valid <= |rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (|rem) begin
            o_stripe_index        <= band;
            o_src_start_px        <= src;
            o_dst_start_px        <= dst;
            o_pixels_per_row      <= i_head.ppr;
            o_row_count           <= rows;
            o_bitmap_handle       <= i_head.bmp;
            o_colour_table_handle <= i_head.pal;
            o_skip_index          <= i_skip;
            o_last_command        <= last;
        end
    end

    assign o_valid = r_valid;

endmodule
`default_nettype wire

### rtl/sprite_stripe_clip_split.sv
// Top level of the sprite stripe splitter: config register, front end, queue, issuer.
// Depends on ssc_pkg, ssc_front, ssc_queue and ssc_back.
//
// Usage:
//  - A sprite (position, bitmap and palette handles) is taken at a clock edge with
//    start high and busy low. The front end culls and clips it in that cycle and
//    files a job of one to three blit commands into a two-entry queue; culled
//    sprites and sprites whose bands are all off screen leave nothing behind.
//  - The issuer sends one command per cycle on the o_ ports, marked by
//    o_cmd_valid for exactly one cycle, in order start, middle, end band; the
//    sprite's final command has o_last_command set.
//  - The first command of an accepted sprite is registered in the queue and then
//    in the issuer's output registers before it is on the ports and taken.
//  - Throughput: a sprite's commands (1 to 3) are issued back to back, culled
//    sprites issue none; the front end takes one sprite per cycle while the
//    queue has room, so busy rises only when the queue is full and the head
//    job is not finishing.
//  - The receiver cannot stall: every command is taken as it is shown.
//  - The transparent index register is written over the cfg channel; ready is
//    high outside reset. Reset empties the queue, drops the output strobe and
//    sets the register to 255; busy is high during reset.
`default_nettype none
module sprite_stripe_clip_split (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [11:0] i_pos_x,
    input  wire logic signed [11:0] i_pos_y,
    input  wire logic [31:0]        i_sprite_base,
    input  wire logic [31:0]        i_palette_base,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_transparent_index,
    output logic                    o_cmd_valid,
    output logic [5:0]              o_stripe_index,
    output logic [9:0]              o_src_start_px,
    output logic [14:0]             o_dst_start_px,
    output logic [5:0]              o_pixels_per_row,
    output logic [5:0]              o_row_count,
    output logic [31:0]             o_bitmap_handle,
    output logic [31:0]             o_colour_table_handle,
    output logic [7:0]              o_skip_index,
    output logic                    o_last_command
);

    logic [7:0]       r_skip;
    logic             keep, pop, accept;
    ssc_pkg::t_job    job, head;
    ssc_pkg::t_qstat  qstat;

    assign o_cfg_ready = i_rst_n;
    assign busy        = !i_rst_n || (qstat.full && !pop);
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 8'hFF;
        end else if (i_cfg_valid) begin
            r_skip <= i_cfg_transparent_index;
        end
    end

    ssc_front u_front (
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_sprite_base  (i_sprite_base),
        .i_palette_base (i_palette_base),
        .o_job          (job),
        .o_keep         (keep)
    );

    ssc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && keep),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    ssc_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_head                (head),
        .i_stat                (qstat),
        .i_skip                (r_skip),
        .o_pop                 (pop),
        .o_valid               (o_cmd_valid),
        .o_stripe_index        (o_stripe_index),
        .o_src_start_px        (o_src_start_px),
        .o_dst_start_px        (o_dst_start_px),
        .o_pixels_per_row      (o_pixels_per_row),
        .o_row_count           (o_row_count),
        .o_bitmap_handle       (o_bitmap_handle),
        .o_colour_table_handle (o_colour_table_handle),
        .o_skip_index          (o_skip_index),
        .o_last_command        (o_last_command)
    );

endmodule
`default_nettype wire

### rtl/ssc_checker.sv
// Port-level checker for the sprite stripe splitter, bound to the top level.
// Depends on ssc_pkg and sprite_stripe_clip_split_assert.svh.
`default_nettype none
`include "sprite_stripe_clip_split_assert.svh"
module ssc_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic signed [11:0] i_pos_x,
    input  wire logic signed [11:0] i_pos_y,
    input  wire logic [31:0]        i_sprite_base,
    input  wire logic [31:0]        i_palette_base,
    input  wire logic               i_cfg_valid,
    input  wire logic               o_cfg_ready,
    input  wire logic [7:0]         i_cfg_transparent_index,
    input  wire logic               o_cmd_valid,
    input  wire logic [5:0]         o_stripe_index,
    input  wire logic [9:0]         o_src_start_px,
    input  wire logic [14:0]        o_dst_start_px,
    input  wire logic [5:0]         o_pixels_per_row,
    input  wire logic [5:0]         o_row_count,
    input  wire logic [31:0]        o_bitmap_handle,
    input  wire logic [31:0]        o_colour_table_handle,
    input  wire logic [7:0]         o_skip_index,
    input  wire logic               o_last_command
);

    // no command leaves in the cycle after reset
    `SSC_ASSERT_NEXT(a_rst_quiet, i_clk, 1'b0, !i_rst_n, !o_cmd_valid)
    // a sprite's commands go out in consecutive beats
    `SSC_ASSERT_NEXT(a_burst, i_clk, !i_rst_n, o_cmd_valid && !o_last_command, o_cmd_valid)
    `SSC_ASSERT_IMPLY(a_ppr, i_clk, !i_rst_n, o_cmd_valid,
        (o_pixels_per_row != 6'd0) && (o_pixels_per_row <= 6'(ssc_pkg::SPR)))
    `SSC_ASSERT_IMPLY(a_rows, i_clk, !i_rst_n, o_cmd_valid,
        (o_row_count != 6'd0) && (o_row_count <= 6'(ssc_pkg::BAND_HEIGHT)))
    `SSC_ASSERT_IMPLY(a_band, i_clk, !i_rst_n, o_cmd_valid,
        o_stripe_index < 6'(ssc_pkg::BAND_COUNT))

endmodule

bind sprite_stripe_clip_split ssc_checker u_ssc_checker (.*);
`default_nettype wire
